>>> rtl/plt_pkg.sv
// Shared types and codes for the positional list table.
// No dependencies; every other file of the block refers to this package.
package plt_pkg;

   localparam int DEFAULT_CAPACITY = 16;
   localparam int VALUE_W          = 32;
   localparam int COUNT_OUT_W      = 5;

   // command codes
   localparam logic [2:0] CMD_APPEND    = 3'd0;
   localparam logic [2:0] CMD_INSERT    = 3'd1;
   localparam logic [2:0] CMD_UPDATE    = 3'd2;
   localparam logic [2:0] CMD_DELETE_AT = 3'd3;
   localparam logic [2:0] CMD_DELETE_BY = 3'd4;

   // status codes
   localparam logic [1:0] STAT_DONE   = 2'd0;
   localparam logic [1:0] STAT_FULL   = 2'd1;
   localparam logic [1:0] STAT_BADPOS = 2'd2;
   localparam logic [1:0] STAT_NOVAL  = 2'd3;

   // cell operation codes broadcast along the chain
   localparam logic [2:0] MODE_HOLD         = 3'd0;
   localparam logic [2:0] MODE_WRITE        = 3'd1;
   localparam logic [2:0] MODE_INSERT       = 3'd2;
   localparam logic [2:0] MODE_REMOVE_AT    = 3'd3;
   localparam logic [2:0] MODE_REMOVE_MATCH = 3'd4;

   typedef struct packed {
      logic [2:0]                command;
      logic [3:0]                position;
      logic signed [VALUE_W-1:0] item_value;
   } plt_req_type;

   typedef struct packed {
      logic [1:0]             status;
      logic [COUNT_OUT_W-1:0] entry_count;
   } plt_rsp_type;

   // broadcast control from the sequencer to every cell
   typedef struct packed {
      logic               eval;
      logic [2:0]         mode;
      logic [VALUE_W-1:0] value;
   } plt_ctl_type;

endpackage

>>> rtl/positional_list_table_core.sv
// Positional list table: top level with the command sequencer and the row of slot cells.
// Depends on plt_pkg and plt_cell.
//
// The block keeps a packed list of up to CAPACITY signed 32-bit values and a live
// count. Each request word carries one command (append, insert at a position, update
// a position, delete at a position if the value matches, delete the first live match
// of a value) and yields exactly one response word with a status and the count after
// the command. A word passes an evaluate state and then an apply state: in the first,
// every cell compares its slot with the request value and registers the result; in the
// second, the sequencer checks bounds and the match flags, a first-match chain ripples
// through the cells, and every cell shifts, writes or holds in the same edge. The split
// is set by that registered compare feeding the update of the shared count and row.
// A new request word is taken in the cycle the previous one finishes, not before;
// a response word waiting on rsp_ready holds the finishing cycle. Slot contents need
// no clearing after reset; only the count, the sequencer state and rsp_valid reset.
module positional_list_table_core #(
   parameter int CAPACITY = plt_pkg::DEFAULT_CAPACITY
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  plt_pkg::plt_req_type req_word,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output plt_pkg::plt_rsp_type rsp_word
);

   localparam int IdxW  = $clog2(CAPACITY);
   localparam int CntW  = $clog2(CAPACITY + 1);
   localparam int WideW = (CntW > plt_pkg::COUNT_OUT_W) ? CntW : plt_pkg::COUNT_OUT_W;
   localparam logic [CntW-1:0] FullCnt = CntW'(CAPACITY);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_EVAL  = 2'd1;
   localparam logic [1:0] ST_APPLY = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [CntW-1:0]      count_ff, count_in;
   plt_pkg::plt_req_type req_ff, req_in;
   plt_pkg::plt_rsp_type rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   plt_pkg::plt_ctl_type        ctl;
   logic [IdxW-1:0]             target_idx;
   logic [1:0]                  status;
   logic                        apply_go;
   logic                        accept;
   logic                        full;
   logic [WideW-1:0]            pos_wide, cnt_wide, new_wide;
   logic [IdxW-1:0]             pos_idx;

   logic [plt_pkg::VALUE_W-1:0] slot_vec [CAPACITY];
   logic [CAPACITY-1:0]         match_vec;
   logic [CAPACITY:0]           found_chain;

   // finish a word only when the response register is free or being drained
   assign apply_go  = (state_ff == ST_APPLY) && (!rsp_valid_ff || rsp_ready);
   assign req_ready = (state_ff == ST_IDLE) || apply_go;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   assign full     = count_ff == FullCnt;
   assign pos_wide = WideW'(req_ff.position);
   assign cnt_wide = WideW'(count_ff);
   assign pos_idx  = pos_wide[IdxW-1:0];
   assign found_chain[0] = 1'b0;

   // decide the command against bounds and registered match flags
   always_comb begin
      ctl.eval   = (state_ff == ST_EVAL);
      ctl.mode   = plt_pkg::MODE_HOLD;
      ctl.value  = $unsigned(req_ff.item_value);
      target_idx = pos_idx;
      status     = plt_pkg::STAT_DONE;
      count_in   = count_ff;
      case (req_ff.command)
         plt_pkg::CMD_APPEND: begin
            if (full) begin
               status = plt_pkg::STAT_FULL;
            end else begin
               ctl.mode   = plt_pkg::MODE_WRITE;
               target_idx = count_ff[IdxW-1:0];
               count_in   = count_ff + 1'b1;
            end
         end
         plt_pkg::CMD_INSERT: begin
            if (full) begin
               status = plt_pkg::STAT_FULL;
            end else if (pos_wide > cnt_wide) begin
               status = plt_pkg::STAT_BADPOS;
            end else begin
               ctl.mode = plt_pkg::MODE_INSERT;
               count_in = count_ff + 1'b1;
            end
         end
         plt_pkg::CMD_UPDATE: begin
            if (pos_wide >= cnt_wide) status = plt_pkg::STAT_BADPOS;
            else ctl.mode = plt_pkg::MODE_WRITE;
         end
         plt_pkg::CMD_DELETE_AT: begin
            if (pos_wide >= cnt_wide) begin
               status = plt_pkg::STAT_BADPOS;
            end else if (!match_vec[pos_idx]) begin
               status = plt_pkg::STAT_NOVAL;
            end else begin
               ctl.mode = plt_pkg::MODE_REMOVE_AT;
               count_in = count_ff - 1'b1;
            end
         end
         plt_pkg::CMD_DELETE_BY: begin
            if (!found_chain[CAPACITY]) begin
               status = plt_pkg::STAT_NOVAL;
            end else begin
               ctl.mode = plt_pkg::MODE_REMOVE_MATCH;
               count_in = count_ff - 1'b1;
            end
         end
         default: status = plt_pkg::STAT_BADPOS;
      endcase
      // drop the update unless the word finishes this cycle
      if (!apply_go) begin
         ctl.mode = plt_pkg::MODE_HOLD;
         count_in = count_ff;
      end
   end

   assign new_wide           = WideW'(count_in);
   assign rsp_in.status      = status;
   assign rsp_in.entry_count = new_wide[plt_pkg::COUNT_OUT_W-1:0];

   // advance the sequencer
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_EVAL;
         ST_EVAL:  state_in = ST_APPLY;
         ST_APPLY: if (apply_go) state_in = accept ? ST_EVAL : ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
      if (accept) req_in = req_word;
      if (apply_go) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      if (apply_go) rsp_ff <= rsp_in;
   end

   // row of slot cells, each handing its value to both neighbors
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [plt_pkg::VALUE_W-1:0] below, above;
      if (g == 0) begin : g_first
         assign below = slot_vec[g];
      end else begin : g_mid_lo
         assign below = slot_vec[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign above = slot_vec[g];
      end else begin : g_mid_hi
         assign above = slot_vec[g+1];
      end
      plt_cell #(
         .CAPACITY (CAPACITY),
         .CELL_ID  (g)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .target_idx (target_idx),
         .live_count (count_ff),
         .slot_below (below),
         .slot_above (above),
         .found_in   (found_chain[g]),
         .slot_out   (slot_vec[g]),
         .match_out  (match_vec[g]),
         .found_out  (found_chain[g+1])
      );
   end

   // count never passes the capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FullCnt)
      else $error("live count above capacity");

   // count moves only when a word finishes
   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !apply_go |=> $stable(count_ff))
      else $error("live count changed outside the finishing cycle");

   // a successful append or insert grows the count by one
   a_count_grow: assert property (@(posedge clock) disable iff (reset)
      apply_go && (status == plt_pkg::STAT_DONE) &&
      ((req_ff.command == plt_pkg::CMD_APPEND) || (req_ff.command == plt_pkg::CMD_INSERT))
      |=> count_ff == $past(count_ff) + 1'b1)
      else $error("append or insert did not grow the count");

   // a response word only follows a finishing cycle or a held one
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_APPLY)
      else $error("response raised without a finishing cycle");

endmodule

>>> rtl/plt_cell.sv
// One slot of the list: holds a value, compares it, and shifts with its neighbors.
// Depends on plt_pkg.
module plt_cell #(
   parameter int CAPACITY = plt_pkg::DEFAULT_CAPACITY,
   parameter int CELL_ID  = 0,
   localparam int IdxW    = $clog2(CAPACITY),
   localparam int CntW    = $clog2(CAPACITY + 1)
) (
   input  logic                         clock,
   input  plt_pkg::plt_ctl_type         ctl,
   input  logic [IdxW-1:0]              target_idx,
   input  logic [CntW-1:0]              live_count,
   input  logic [plt_pkg::VALUE_W-1:0]  slot_below,
   input  logic [plt_pkg::VALUE_W-1:0]  slot_above,
   input  logic                         found_in,
   output logic [plt_pkg::VALUE_W-1:0]  slot_out,
   output logic                         match_out,
   output logic                         found_out
);

   localparam logic [IdxW-1:0] MyIdx = IdxW'(CELL_ID);
   localparam logic [CntW-1:0] MyCnt = CntW'(CELL_ID);

   logic [plt_pkg::VALUE_W-1:0] slot_ff, slot_in;
   logic                        match_ff, match_in;
   logic                        live;

   assign live      = MyCnt < live_count;
   assign found_out = found_in | (live & match_ff);
   assign match_out = match_ff;
   assign slot_out  = slot_ff;
   assign match_in  = ctl.eval ? (slot_ff == ctl.value) : match_ff;

   always_comb begin
      slot_in = slot_ff;
      case (ctl.mode)
         plt_pkg::MODE_WRITE: begin
            if (MyIdx == target_idx) slot_in = ctl.value;
         end
         plt_pkg::MODE_INSERT: begin
            if (MyIdx == target_idx) slot_in = ctl.value;
            else if (MyIdx > target_idx) slot_in = slot_below;
         end
         plt_pkg::MODE_REMOVE_AT: begin
            if (MyIdx >= target_idx) slot_in = slot_above;
         end
         plt_pkg::MODE_REMOVE_MATCH: begin
            if (found_out) slot_in = slot_above;
         end
         default: slot_in = slot_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      slot_ff  <= slot_in;
      match_ff <= match_in;
   end

endmodule

>>> dv/positional_list_table_core_test.sv
// Self-checking testbench for positional_list_table_core: list edit commands in, status words out.
// Depends on plt_pkg and the block's RTL; a local list model predicts every response word.
`timescale 1ns / 100ps

module positional_list_table_core_test;

   localparam int TABLE_DEPTH  = plt_pkg::DEFAULT_CAPACITY;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_WORDS = 1020;
   localparam int SETTLE_WAIT  = 8;

   // command codes the block does not define; it must answer them with a bad position
   localparam logic [2:0] CMD_RESERVED_FIRST = 3'd5;
   localparam logic [2:0] CMD_RESERVED_LAST  = 3'd7;

   typedef enum int {
      READY_ALWAYS,
      READY_COIN,
      READY_MOSTLY,
      READY_PERIODIC
   } ready_style_type;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   plt_pkg::plt_req_type req_word  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   plt_pkg::plt_rsp_type rsp_word;

   // model of the list as the block should hold it after every accepted word
   logic [plt_pkg::VALUE_W-1:0] list_slots [TABLE_DEPTH];
   int                          list_count = 0;

   // response words still owed by the block, oldest first
   plt_pkg::plt_rsp_type pending_outcomes [$];

   int error_count     = 0;
   int cycle_count     = 0;
   int hold_off_cycles = 0;
   int burst_left      = 0;
   bit growing         = 1'b1;

   positional_list_table_core #(
      .CAPACITY(TABLE_DEPTH)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_word (req_word),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_word (rsp_word)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // List model
   // ------------------------------------------------------------------

   // close the gap at pos by pulling every later live entry down one slot
   function automatic void remove_entry(int pos);
      for (int i = pos; i + 1 < list_count; i++)
         list_slots[i] = list_slots[i + 1];
      list_count--;
   endfunction

   // apply one command to the model list and return the response word it owes
   function automatic plt_pkg::plt_rsp_type apply_command(plt_pkg::plt_req_type w);
      plt_pkg::plt_rsp_type outcome;
      int                   pos;
      outcome.status = plt_pkg::STAT_DONE;
      pos = int'(w.position);
      case (w.command)
         plt_pkg::CMD_APPEND: begin
            if (list_count >= TABLE_DEPTH) begin
               outcome.status = plt_pkg::STAT_FULL;
            end else begin
               list_slots[list_count] = w.item_value;
               list_count++;
            end
         end
         plt_pkg::CMD_INSERT: begin
            // the full check wins over the position check
            if (list_count >= TABLE_DEPTH) begin
               outcome.status = plt_pkg::STAT_FULL;
            end else if (pos > list_count) begin
               outcome.status = plt_pkg::STAT_BADPOS;
            end else begin
               for (int i = list_count; i > pos; i--)
                  list_slots[i] = list_slots[i - 1];
               list_slots[pos] = w.item_value;
               list_count++;
            end
         end
         plt_pkg::CMD_UPDATE: begin
            if (pos >= list_count)
               outcome.status = plt_pkg::STAT_BADPOS;
            else
               list_slots[pos] = w.item_value;
         end
         plt_pkg::CMD_DELETE_AT: begin
            if (pos >= list_count)
               outcome.status = plt_pkg::STAT_BADPOS;
            else if (list_slots[pos] != w.item_value)
               outcome.status = plt_pkg::STAT_NOVAL;
            else
               remove_entry(pos);
         end
         plt_pkg::CMD_DELETE_BY: begin
            // only the first live match goes
            outcome.status = plt_pkg::STAT_NOVAL;
            for (int i = 0; i < list_count; i++) begin
               if (list_slots[i] == w.item_value) begin
                  remove_entry(i);
                  outcome.status = plt_pkg::STAT_DONE;
                  break;
               end
            end
         end
         default: outcome.status = plt_pkg::STAT_BADPOS;
      endcase
      outcome.entry_count = plt_pkg::COUNT_OUT_W'(list_count);
      return outcome;
   endfunction

   function automatic plt_pkg::plt_req_type make_word(logic [2:0] cmd, int pos,
                                                      logic [plt_pkg::VALUE_W-1:0] val);
      plt_pkg::plt_req_type w;
      w.command    = cmd;
      w.position   = 4'(pos);
      w.item_value = val;
      return w;
   endfunction

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------

   // Offer one word, hold it until accepted, then predict its response.
   // Bursts of random length end in a random gap with valid low.
   task automatic send_word(plt_pkg::plt_req_type w);
      int gap;
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      pending_outcomes.push_back(apply_command(w));
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   // drop valid and stall until every owed response word is back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (pending_outcomes.size() != 0);
   endtask

   // ------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------

   // Receiver: stall on a changing pattern, or hold off for a long stretch on request.
   initial begin : receiver
      ready_style_type style;
      int              style_left;
      int              phase;
      style      = READY_ALWAYS;
      style_left = 0;
      phase      = 0;
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_off_cycles) @(posedge clock);
            hold_off_cycles = 0;
         end else begin
            if (style_left == 0) begin
               style      = ready_style_type'($urandom_range(0, 3));
               style_left = $urandom_range(20, 120);
            end
            style_left--;
            phase++;
            case (style)
               READY_ALWAYS: rsp_ready <= 1'b1;
               READY_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
               READY_MOSTLY: rsp_ready <= ($urandom_range(0, 4) != 0);
               default:      rsp_ready <= ((phase % 5) < 2);
            endcase
         end
      end
   end

   // Compare every accepted response word with the oldest one owed.
   always @(posedge clock) begin : check_response
      plt_pkg::plt_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outcomes.size() == 0) begin
            error_count++;
            $display("%0t: response word with none owed: status %0d count %0d",
                     $time, rsp_word.status, rsp_word.entry_count);
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_word.status !== want.status) begin
               error_count++;
               $display("%0t: status mismatch: expected %0d, actual %0d",
                        $time, want.status, rsp_word.status);
            end
            if (rsp_word.entry_count !== want.entry_count) begin
               error_count++;
               $display("%0t: entry_count mismatch: expected %0d, actual %0d",
                        $time, want.entry_count, rsp_word.entry_count);
            end
         end
      end
   end

   // Watchdog: end the run if the block hangs.
   always @(posedge clock)
      cycle_count <= cycle_count + 1;

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Verification failed");
      $finish;
   end

   // ------------------------------------------------------------------
   // Random stimulus helpers
   // ------------------------------------------------------------------

   // favor live values so matches happen, then the extremes, then anything
   function automatic logic [plt_pkg::VALUE_W-1:0] pick_value();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 4 && list_count > 0)
         return list_slots[$urandom_range(0, list_count - 1)];
      if (roll == 4)
         return 32'h8000_0000;
      if (roll == 5)
         return 32'h7FFF_FFFF;
      if (roll == 6)
         return 32'($urandom_range(0, 3));
      return $urandom;
   endfunction

   // Build a mostly well-formed command; the growing phase pushes toward full,
   // the shrinking phase toward empty, and a few words are pure noise.
   function automatic plt_pkg::plt_req_type next_random_word();
      plt_pkg::plt_req_type w;
      int                   roll;
      int                   append_lim;
      int                   insert_lim;
      int                   update_lim;
      int                   delete_lim;
      roll       = $urandom_range(0, 99);
      append_lim = growing ? 35 : 10;
      insert_lim = growing ? 60 : 20;
      update_lim = growing ? 75 : 35;
      delete_lim = growing ? 85 : 65;
      w.item_value = pick_value();
      w.position   = (list_count > 0) ? 4'($urandom_range(0, list_count - 1)) : 4'd0;
      if (roll >= 95) begin
         w.command    = 3'($urandom_range(0, 7));
         w.position   = 4'($urandom);
         w.item_value = $urandom;
         return w;
      end
      if (roll < append_lim)
         w.command = plt_pkg::CMD_APPEND;
      else if (roll < insert_lim)
         w.command = plt_pkg::CMD_INSERT;
      else if (roll < update_lim)
         w.command = plt_pkg::CMD_UPDATE;
      else if (roll < delete_lim)
         w.command = plt_pkg::CMD_DELETE_AT;
      else
         w.command = plt_pkg::CMD_DELETE_BY;
      if (w.command == plt_pkg::CMD_INSERT)
         w.position = 4'($urandom_range(0, (list_count < TABLE_DEPTH) ? list_count : 15));
      // now and then aim at a position past the live entries
      if ($urandom_range(0, 9) == 0)
         w.position = 4'($urandom);
      if (w.command == plt_pkg::CMD_DELETE_AT && int'(w.position) < list_count
          && $urandom_range(0, 4) != 0)
         w.item_value = list_slots[w.position];
      return w;
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // every command but append on an empty list, plus the first and last undefined codes
   task automatic test_empty_list();
      send_word(make_word(plt_pkg::CMD_DELETE_BY, 0, 32'd0));
      send_word(make_word(plt_pkg::CMD_UPDATE, 0, 32'd1));
      send_word(make_word(plt_pkg::CMD_DELETE_AT, 0, 32'd0));
      send_word(make_word(plt_pkg::CMD_INSERT, 1, 32'd2));
      send_word(make_word(CMD_RESERVED_FIRST, 0, 32'hFFFF_FFFF));
      send_word(make_word(CMD_RESERVED_LAST, 15, 32'h8000_0000));
   endtask

   // fill to capacity with extreme and repeated values
   task automatic test_fill_to_capacity();
      logic [plt_pkg::VALUE_W-1:0] fill_values [14];
      fill_values = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
                      32'd7, 32'd7, 32'd3, 32'h8000_0000, 32'd9, 32'd7, 32'd1,
                      32'd2, 32'd3, 32'h7FFF_FFFF};
      send_word(make_word(plt_pkg::CMD_INSERT, 0, 32'h8000_0000));
      send_word(make_word(plt_pkg::CMD_APPEND, 15, 32'h7FFF_FFFF));
      foreach (fill_values[k])
         send_word(make_word(plt_pkg::CMD_APPEND, k, fill_values[k]));
   endtask

   // edits at and around the full list: refusals, last slot, first match
   task automatic test_full_list_edits();
      send_word(make_word(plt_pkg::CMD_APPEND, 0, 32'd11));
      send_word(make_word(plt_pkg::CMD_INSERT, 4, 32'd11));
      send_word(make_word(plt_pkg::CMD_UPDATE, 15, 32'h1234_5678));
      send_word(make_word(plt_pkg::CMD_DELETE_AT, 15, 32'd0));
      send_word(make_word(plt_pkg::CMD_DELETE_AT, 15, 32'h1234_5678));
      send_word(make_word(plt_pkg::CMD_DELETE_BY, 0, 32'd7));
      send_word(make_word(plt_pkg::CMD_DELETE_BY, 0, 32'hDEAD_BEEF));
      send_word(make_word(plt_pkg::CMD_UPDATE, 15, 32'd5));
      send_word(make_word(plt_pkg::CMD_INSERT, 14, 32'd42));
   endtask

   // Hold the receiver off for a long stretch while words keep coming, so the
   // block fills and stalls req_ready; then pause until all responses are back.
   task automatic test_backpressure();
      hold_off_cycles = 200;
      for (int n = 0; n < 12; n++)
         send_word(next_random_word());
      wait_for_drain();
   endtask

   // long random run with phase-biased commands and occasional full drains
   task automatic test_random_traffic(int words);
      for (int n = 0; n < words; n++) begin
         if (growing && list_count == TABLE_DEPTH && $urandom_range(0, 3) == 0)
            growing = 1'b0;
         else if (!growing && list_count == 0 && $urandom_range(0, 1) == 0)
            growing = 1'b1;
         else if ($urandom_range(0, 79) == 0)
            growing = !growing;
         send_word(next_random_word());
         if ($urandom_range(0, 149) == 0)
            wait_for_drain();
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_list();
      test_fill_to_capacity();
      test_full_list_edits();
      test_backpressure();
      test_random_traffic(RANDOM_WORDS);
      wait_for_drain();
      repeat (SETTLE_WAIT) @(posedge clock);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
